@@ design/text_layout_cursor_assert.svh @@
// Assertion macros shared by the text layout cursor design.
`ifndef TEXT_LAYOUT_CURSOR_ASSERT_SVH
`define TEXT_LAYOUT_CURSOR_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define TLC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define TLC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/tlc_pkg.sv @@
// Package with the result kinds, register indexes and constants of the text layout cursor.
`default_nettype none

package tlc_pkg;

    typedef enum logic [1:0] {
        KIND_NARROW = 2'd0,
        KIND_WIDE   = 2'd1,
        KIND_FULL   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        CFG_AREA_WIDTH  = 2'd0,
        CFG_AREA_HEIGHT = 2'd1,
        CFG_FONT_SIZE   = 2'd2,
        CFG_OVERLAY     = 2'd3
    } cfg_index_t;

    localparam logic [7:0]  WIDE_LEAD_ABOVE     = 8'h80;
    localparam logic [7:0]  CARRIAGE_RETURN     = 8'd13;
    localparam logic [15:0] AREA_WIDTH_RESET    = 16'd320;
    localparam logic [15:0] AREA_HEIGHT_RESET   = 16'd240;
    localparam logic [7:0]  FONT_SIZE_RESET     = 8'd16;

endpackage

`default_nettype wire

@@ design/text_layout_cursor.sv @@
// Top level of the text layout cursor: places text bytes in an area and emits draw commands.
// Data path: an accepted byte is captured in the input register at its transfer edge, and its
// result, if any, is loaded from there into the output register when the byte is consumed.
// Throughput: one byte per cycle; the cursor state updates in the same cycle that
// consumes the input register, and only a held result in the output register stalls it.
// Reset (aresetn low, synchronous): registers return to their reset values and the block
// drops all bytes until one with first set.
`default_nettype none

module text_layout_cursor
    import tlc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_text_byte,
    input  wire logic        s_first,
    input  wire logic [15:0] s_start_x,
    input  wire logic [15:0] s_start_y,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_kind,
    output logic [15:0]      m_pos_x,
    output logic [15:0]      m_pos_y,
    output logic [23:0]      m_char_code
);

    // Configuration registers.
    logic [15:0] area_width_reg;
    logic [15:0] area_height_reg;
    logic [7:0]  font_size_reg;

    // Input register.
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_first_reg;
    logic [15:0] in_start_x_reg;
    logic [15:0] in_start_y_reg;

    // Layout state.
    logic [15:0] cursor_x_reg, cursor_x_next;
    logic [15:0] cursor_y_reg, cursor_y_next;
    logic [15:0] origin_x_reg, origin_x_next;
    logic [15:0] origin_y_reg, origin_y_next;
    logic [1:0]  wide_seen_reg, wide_seen_next;
    logic [15:0] wide_code_reg, wide_code_next;
    logic        skip_reg, skip_next;
    logic        stopped_reg, stopped_next;

    // Output register.
    logic        out_valid_reg;
    kind_t       kind_reg, kind_next;
    logic [15:0] pos_x_reg, pos_x_next;
    logic [15:0] pos_y_reg, pos_y_next;
    logic [23:0] code_reg, code_next;

    logic        has_result;
    logic        advance;

    // Effective state after a first byte has loaded the origin.
    logic [15:0] cx_e, cy_e, ox_e, oy_e;
    logic [1:0]  ws_e;
    logic [15:0] wc_e;
    logic        skip_e, stopped_e;

    logic        use_wide;
    logic [7:0]  item_w;
    logic signed [17:0] right_edge;
    logic signed [17:0] bottom_edge;
    logic        wrap;
    logic [15:0] cx_w, cy_w;
    logic        full;

    assign cfg_ready = 1'b1;

    // The overlay mode only matters to the draw units, so its writes change nothing here.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            area_width_reg  <= AREA_WIDTH_RESET;
            area_height_reg <= AREA_HEIGHT_RESET;
            font_size_reg   <= FONT_SIZE_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_AREA_WIDTH:  area_width_reg  <= cfg_data;
                CFG_AREA_HEIGHT: area_height_reg <= cfg_data;
                CFG_FONT_SIZE:   font_size_reg   <= cfg_data[7:0];
                CFG_OVERLAY: begin
                end
                default: begin
                end
            endcase
        end
    end

    assign advance = in_valid_reg && (!has_result || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg    <= s_text_byte;
            in_first_reg   <= s_first;
            in_start_x_reg <= s_start_x;
            in_start_y_reg <= s_start_y;
        end
    end

    always_comb begin
        if (in_first_reg) begin
            ox_e      = in_start_x_reg;
            oy_e      = in_start_y_reg;
            cx_e      = in_start_x_reg;
            cy_e      = in_start_y_reg;
            ws_e      = 2'd0;
            wc_e      = 16'd0;
            skip_e    = 1'b0;
            stopped_e = 1'b0;
        end else begin
            ox_e      = origin_x_reg;
            oy_e      = origin_y_reg;
            cx_e      = cursor_x_reg;
            cy_e      = cursor_y_reg;
            ws_e      = wide_seen_reg;
            wc_e      = wide_code_reg;
            skip_e    = skip_reg;
            stopped_e = stopped_reg;
        end
    end

    // Wrap and bottom tests in 18-bit signed arithmetic, which is exact for these ranges.
    always_comb begin
        use_wide    = (ws_e == 2'd2);
        item_w      = use_wide ? font_size_reg : {1'b0, font_size_reg[7:1]};
        right_edge  = $signed({2'b00, ox_e}) + $signed({2'b00, area_width_reg})
                    - $signed({10'd0, item_w});
        bottom_edge = $signed({2'b00, oy_e}) + $signed({2'b00, area_height_reg})
                    - $signed({10'd0, font_size_reg});
        wrap        = $signed({2'b00, cx_e}) > right_edge;
        cx_w        = wrap ? ox_e : cx_e;
        cy_w        = wrap ? cy_e + {8'd0, font_size_reg} : cy_e;
        full        = $signed({2'b00, cy_w}) > bottom_edge;
    end

    always_comb begin
        cursor_x_next  = cx_e;
        cursor_y_next  = cy_e;
        origin_x_next  = ox_e;
        origin_y_next  = oy_e;
        wide_seen_next = ws_e;
        wide_code_next = wc_e;
        skip_next      = skip_e;
        stopped_next   = stopped_e;
        has_result     = 1'b0;
        kind_next      = KIND_NARROW;
        pos_x_next     = cx_w;
        pos_y_next     = cy_w;
        code_next      = 24'd0;

        if (stopped_e) begin
            // Bytes are dropped until a new string starts.
        end else if (in_byte_reg == 8'd0) begin
            stopped_next   = 1'b1;
            wide_seen_next = 2'd0;
            skip_next      = 1'b0;
        end else if (skip_e) begin
            skip_next = 1'b0;
        end else if (ws_e == 2'd1) begin
            wide_code_next = {wc_e[7:0], in_byte_reg};
            wide_seen_next = 2'd2;
        end else if (ws_e == 2'd2) begin
            wide_seen_next = 2'd0;
            cursor_x_next  = cx_w;
            cursor_y_next  = cy_w;
            has_result     = 1'b1;
            if (full) begin
                kind_next    = KIND_FULL;
                stopped_next = 1'b1;
            end else begin
                kind_next     = KIND_WIDE;
                code_next     = {wc_e, in_byte_reg};
                cursor_x_next = cx_w + {8'd0, font_size_reg};
            end
        end else if (in_byte_reg > WIDE_LEAD_ABOVE) begin
            wide_code_next = {8'd0, in_byte_reg};
            wide_seen_next = 2'd1;
        end else begin
            cursor_x_next = cx_w;
            cursor_y_next = cy_w;
            if (full) begin
                has_result   = 1'b1;
                kind_next    = KIND_FULL;
                stopped_next = 1'b1;
            end else if (in_byte_reg == CARRIAGE_RETURN) begin
                cursor_x_next = ox_e;
                cursor_y_next = cy_w + {8'd0, font_size_reg};
                skip_next     = 1'b1;
            end else begin
                has_result    = 1'b1;
                kind_next     = KIND_NARROW;
                code_next     = {16'd0, in_byte_reg};
                cursor_x_next = cx_w + {9'd0, font_size_reg[7:1]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_x_reg  <= 16'd0;
            cursor_y_reg  <= 16'd0;
            origin_x_reg  <= 16'd0;
            origin_y_reg  <= 16'd0;
            wide_seen_reg <= 2'd0;
            wide_code_reg <= 16'd0;
            skip_reg      <= 1'b0;
            stopped_reg   <= 1'b1;
        end else if (advance) begin
            cursor_x_reg  <= cursor_x_next;
            cursor_y_reg  <= cursor_y_next;
            origin_x_reg  <= origin_x_next;
            origin_y_reg  <= origin_y_next;
            wide_seen_reg <= wide_seen_next;
            wide_code_reg <= wide_code_next;
            skip_reg      <= skip_next;
            stopped_reg   <= stopped_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && has_result) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && has_result) begin
            kind_reg  <= kind_next;
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
            code_reg  <= code_next;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_kind      = kind_reg;
    assign m_pos_x     = pos_x_reg;
    assign m_pos_y     = pos_y_reg;
    assign m_char_code = code_reg;

`include "text_layout_cursor_assert.svh"

    `TLC_ASSERT_NEXT(a_input_captured, s_valid && s_ready, in_valid_reg, "input transfer lost")
    `TLC_ASSERT_NEXT(a_input_held, in_valid_reg && !advance, in_valid_reg, "held byte dropped")
    `TLC_ASSERT_SAME(a_full_no_code, m_valid && (m_kind == KIND_FULL), m_char_code == 24'd0,
        "area full result carries a code")

endmodule

`default_nettype wire

@@ tb/sv/text_layout_cursor_tb.sv @@
// Self-checking testbench for the text layout cursor with random stimulus and flow control.
`default_nettype none

module text_layout_cursor_tb;
    import tlc_pkg::*;

    localparam int ITEMS_PER_PHASE = 130;
    localparam int RANDOM_PHASES   = 7;
    localparam int IDLE_GUARD      = 4;
    localparam int TAIL_CYCLES     = 20;
    localparam int LONG_HOLD       = 400;
    localparam int STALL_LIMIT     = 5000;
    localparam int REPORT_LIMIT    = 10;

    localparam int RX_OPEN   = 0;
    localparam int RX_RANDOM = 1;
    localparam int RX_SPARSE = 2;
    localparam int RX_TOGGLE = 3;

    typedef struct packed {
        logic [7:0]  ch;
        logic        first;
        logic [15:0] sx;
        logic [15:0] sy;
    } text_item_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] x;
        logic [15:0] y;
        logic [23:0] code;
    } draw_cmd_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_text_byte = '0;
    logic        s_first = 1'b0;
    logic [15:0] s_start_x = '0;
    logic [15:0] s_start_y = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_kind;
    logic [15:0] m_pos_x;
    logic [15:0] m_pos_y;
    logic [23:0] m_char_code;

    text_layout_cursor u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_text_byte (s_text_byte),
        .s_first     (s_first),
        .s_start_x   (s_start_x),
        .s_start_y   (s_start_y),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_kind      (m_kind),
        .m_pos_x     (m_pos_x),
        .m_pos_y     (m_pos_y),
        .m_char_code (m_char_code)
    );

    always #5 aclk = ~aclk;

    // Layout settings as the block should hold them.
    logic [15:0] area_w     = AREA_WIDTH_RESET;
    logic [15:0] area_h     = AREA_HEIGHT_RESET;
    logic [7:0]  font_sz    = FONT_SIZE_RESET;
    logic        overlay_md = 1'b0;

    // Cursor state of the layout predictor.
    logic [15:0] cur_x, cur_y, org_x, org_y;
    logic [1:0]  wide_cnt;
    logic [15:0] wide_acc;
    logic        skip_pending;
    logic        halted;

    text_item_t text_q[$];
    draw_cmd_t  draw_q[$];
    text_item_t next_item;
    int         items_queued = 0;
    int         mismatches = 0;
    int         send_gap, send_burst;
    int         hold_requests = 0;
    int         holds_served, hold_left, mode_left, rx_mode;
    int         stall_cycles = 0;

    // Wraps when the item would pass the right edge, then tests the bottom edge.
    function automatic bit wrap_or_full(input int item_w);
        int right_edge, bottom_edge;
        right_edge = int'(org_x) + int'(area_w) - item_w;
        bottom_edge = int'(org_y) + int'(area_h) - int'(font_sz);
        if (int'(cur_x) > right_edge) begin
            cur_y = cur_y + {8'd0, font_sz};
            cur_x = org_x;
        end
        if (int'(cur_y) > bottom_edge) begin
            draw_q.push_back('{kind: KIND_FULL, x: cur_x, y: cur_y, code: 24'd0});
            halted = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void layout_byte(input text_item_t it);
        logic [23:0] glyph;
        if (it.first) begin
            org_x = it.sx;
            org_y = it.sy;
            cur_x = it.sx;
            cur_y = it.sy;
            halted = 1'b0;
            skip_pending = 1'b0;
            wide_cnt = 2'd0;
            wide_acc = 16'd0;
        end
        if (halted)
            return;
        if (it.ch == 8'd0) begin
            halted = 1'b1;
            wide_cnt = 2'd0;
            skip_pending = 1'b0;
            return;
        end
        if (skip_pending) begin
            skip_pending = 1'b0;
            return;
        end
        if (wide_cnt == 2'd1) begin
            wide_acc = {wide_acc[7:0], it.ch};
            wide_cnt = 2'd2;
            return;
        end
        if (wide_cnt == 2'd2) begin
            wide_cnt = 2'd0;
            glyph = {wide_acc, it.ch};
            if (wrap_or_full(int'(font_sz)))
                return;
            draw_q.push_back('{kind: KIND_WIDE, x: cur_x, y: cur_y, code: glyph});
            cur_x = cur_x + {8'd0, font_sz};
            return;
        end
        if (it.ch > WIDE_LEAD_ABOVE) begin
            wide_acc = {8'd0, it.ch};
            wide_cnt = 2'd1;
            return;
        end
        if (wrap_or_full(int'(font_sz >> 1)))
            return;
        if (it.ch == CARRIAGE_RETURN) begin
            cur_y = cur_y + {8'd0, font_sz};
            cur_x = org_x;
            skip_pending = 1'b1;
            return;
        end
        draw_q.push_back('{kind: KIND_NARROW, x: cur_x, y: cur_y, code: {16'd0, it.ch}});
        cur_x = cur_x + {9'd0, font_sz[7:1]};
    endfunction

    // Input driver: bursts of transfers separated by random gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap = 0;
            send_burst = 0;
            cur_x = '0;
            cur_y = '0;
            org_x = '0;
            org_y = '0;
            wide_cnt = '0;
            wide_acc = '0;
            skip_pending = 1'b0;
            halted = 1'b1;
        end else begin
            if (s_valid && s_ready)
                layout_byte('{ch: s_text_byte, first: s_first, sx: s_start_x, sy: s_start_y});
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (text_q.size() > 0) begin
                    next_item = text_q.pop_front();
                    s_valid <= 1'b1;
                    s_text_byte <= next_item.ch;
                    s_first <= next_item.first;
                    s_start_x <= next_item.sx;
                    s_start_y <= next_item.sy;
                    if (send_burst > 0) begin
                        send_burst--;
                    end else begin
                        send_burst = $urandom_range(1, 32);
                        if ($urandom_range(0, 2) == 0)
                            send_gap = 0;
                        else if ($urandom_range(0, 9) == 0)
                            send_gap = $urandom_range(6, 24);
                        else
                            send_gap = $urandom_range(1, 5);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver flow control.
    always @(posedge aclk) begin
        draw_cmd_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            holds_served = 0;
            hold_left = 0;
            mode_left = 0;
            rx_mode = RX_OPEN;
        end else begin
            if (m_valid && m_ready) begin
                if (draw_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("unexpected result: kind %0d pos (%0d,%0d) code %06h",
                                 m_kind, m_pos_x, m_pos_y, m_char_code);
                end else begin
                    want = draw_q.pop_front();
                    if (m_kind !== want.kind || m_pos_x !== want.x || m_pos_y !== want.y ||
                        m_char_code !== want.code) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display({"mismatch: expected kind %0d pos (%0d,%0d) code %06h,",
                                      " got kind %0d pos (%0d,%0d) code %06h"},
                                     want.kind, want.x, want.y, want.code,
                                     m_kind, m_pos_x, m_pos_y, m_char_code);
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (holds_served < hold_requests) begin
                holds_served++;
                hold_left = LONG_HOLD;
                m_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode = $urandom_range(RX_OPEN, RX_TOGGLE);
                    mode_left = $urandom_range(20, 200);
                end else begin
                    mode_left--;
                end
                case (rx_mode)
                    RX_OPEN:   m_ready <= 1'b1;
                    RX_RANDOM: m_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                    default:   m_ready <= ~m_ready;
                endcase
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic queue_item(input logic [7:0] ch, input logic first,
                              input logic [15:0] sx, input logic [15:0] sy);
        text_q.push_back('{ch: ch, first: first, sx: sx, sy: sy});
        items_queued++;
    endtask

    function automatic logic [15:0] pick_origin();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return 16'($urandom_range(0, 200));
        else if (pick < 85)
            return 16'($urandom_range(65000, 65535));
        return 16'($urandom_range(0, 65535));
    endfunction

    // Sampled at the falling edge so that no update of this cycle is missed.
    task automatic wait_drained();
        do @(negedge aclk); while (text_q.size() != 0 || s_valid || draw_q.size() != 0);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_AREA_WIDTH:  area_w = data;
            CFG_AREA_HEIGHT: area_h = data;
            CFG_FONT_SIZE:   font_sz = data[7:0];
            default:         overlay_md = data[0];
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic write_layout(input logic [15:0] w, input logic [15:0] h,
                                input logic [7:0] font, input logic ov);
        wait_drained();
        // An item that gives no result may still be in flight.
        repeat (IDLE_GUARD) @(posedge aclk);
        write_reg(CFG_AREA_WIDTH, w);
        write_reg(CFG_AREA_HEIGHT, h);
        write_reg(CFG_FONT_SIZE, {8'($urandom_range(0, 255)), font});
        write_reg(CFG_OVERLAY, {15'($urandom_range(0, 32767)), ov});
    endtask

    // A string with random content, or now and then a stray byte.
    task automatic add_string();
        int parts, pick;
        if ($urandom_range(0, 9) == 0) begin
            queue_item(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                       16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
            return;
        end
        if ($urandom_range(0, 7) == 0)
            queue_item(8'($urandom_range(0, 255)), 1'b1, pick_origin(), pick_origin());
        else
            queue_item(8'($urandom_range(1, 128)), 1'b1, pick_origin(), pick_origin());
        parts = $urandom_range(0, 24);
        repeat (parts) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                queue_item(8'($urandom_range(1, 128)), 1'b0,
                           16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
            end else if (pick < 80) begin
                queue_item(8'($urandom_range(129, 255)), 1'b0,
                           16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
                repeat (2)
                    queue_item(8'($urandom_range(1, 255)), 1'b0,
                               16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
            end else if (pick < 92) begin
                queue_item(CARRIAGE_RETURN, 1'b0,
                           16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
                queue_item(($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 255)),
                           1'b0, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
            end else begin
                queue_item(8'($urandom_range(0, 255)), 1'b0,
                           16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
            end
        end
        if ($urandom_range(0, 3) != 0)
            queue_item(8'd0, 1'b0, 16'($urandom_range(0, 65535)),
                       16'($urandom_range(0, 65535)));
    endtask

    initial begin
        int          phase, target;
        logic [15:0] new_w, new_h;
        logic [7:0]  new_font;
        logic        new_ov;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Settings after reset: narrow, wide, carriage return and overflow cases.
        queue_item("Z", 1'b0, 16'd1234, 16'd5678);
        queue_item("A", 1'b1, 16'd0, 16'd0);
        queue_item(8'h80, 1'b0, 16'd0, 16'd0);
        queue_item(8'h01, 1'b0, 16'hFFFF, 16'hFFFF);
        queue_item(8'hFF, 1'b0, 16'd0, 16'd0);
        queue_item(8'hFF, 1'b0, 16'd0, 16'd0);
        queue_item(8'hFF, 1'b0, 16'd0, 16'd0);
        queue_item(CARRIAGE_RETURN, 1'b0, 16'd0, 16'd0);
        queue_item(8'hE5, 1'b0, 16'd0, 16'd0);
        queue_item("H", 1'b0, 16'd0, 16'd0);
        queue_item(CARRIAGE_RETURN, 1'b0, 16'd0, 16'd0);
        queue_item(8'h00, 1'b0, 16'd0, 16'd0);
        queue_item("Q", 1'b0, 16'd0, 16'd0);
        queue_item("B", 1'b1, 16'hFFFF, 16'hFFFF);
        queue_item("C", 1'b0, 16'd0, 16'd0);
        queue_item(8'h90, 1'b0, 16'd0, 16'd0);
        queue_item("x", 1'b0, 16'd0, 16'd0);
        queue_item(8'h00, 1'b0, 16'd0, 16'd0);
        queue_item(8'hA0, 1'b1, 16'd100, 16'd100);
        queue_item(8'h41, 1'b0, 16'd0, 16'd0);
        queue_item("K", 1'b1, 16'd200, 16'd50);
        queue_item(8'h00, 1'b0, 16'd0, 16'd0);

        // Tiny area: wrap into area full, drop while stopped, wide glyph placement.
        write_layout(16'd16, 16'd16, 8'd16, 1'b1);
        queue_item("a", 1'b1, 16'd10, 16'd20);
        queue_item("b", 1'b0, 16'd0, 16'd0);
        queue_item("c", 1'b0, 16'd0, 16'd0);
        queue_item("d", 1'b0, 16'd0, 16'd0);
        queue_item(8'h00, 1'b1, 16'd0, 16'd0);
        queue_item(CARRIAGE_RETURN, 1'b1, 16'd0, 16'd0);
        queue_item("e", 1'b0, 16'd0, 16'd0);
        queue_item("f", 1'b0, 16'd0, 16'd0);
        queue_item(8'hC3, 1'b1, 16'd0, 16'd0);
        queue_item(8'h01, 1'b0, 16'd0, 16'd0);
        queue_item(8'h80, 1'b0, 16'd0, 16'd0);
        queue_item("g", 1'b0, 16'd0, 16'd0);

        // Empty area with the largest font, at both ends of the coordinate range.
        write_layout(16'd0, 16'd0, 8'd255, 1'b0);
        queue_item("A", 1'b1, 16'd0, 16'd0);
        queue_item("B", 1'b1, 16'hFFFF, 16'hFFFF);
        queue_item(8'hFE, 1'b0, 16'd0, 16'd0);
        queue_item(8'h7F, 1'b0, 16'd0, 16'd0);
        queue_item(8'h55, 1'b0, 16'd0, 16'd0);

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: begin new_w = 16'hFFFF; new_h = 16'hFFFF; new_font = 8'd1; new_ov = 1'b0; end
                1: begin new_w = 16'd100; new_h = 16'd60; new_font = 8'd8; new_ov = 1'b1; end
                2: begin
                    new_w = 16'($urandom_range(0, 400));
                    new_h = 16'($urandom_range(0, 300));
                    new_font = 8'd0;
                    new_ov = 1'($urandom_range(0, 1));
                end
                3: begin new_w = 16'd300; new_h = 16'd200; new_font = 8'd255; new_ov = 1'b1; end
                default: begin
                    new_w = 16'($urandom_range(0, 500));
                    new_h = 16'($urandom_range(0, 400));
                    new_font = 8'($urandom_range(1, 40));
                    new_ov = 1'($urandom_range(0, 1));
                end
            endcase
            write_layout(new_w, new_h, new_font, new_ov);
            target = items_queued + ITEMS_PER_PHASE;
            while (items_queued < target - ITEMS_PER_PHASE / 2)
                add_string();
            // The sender holds back until every pending result has been seen.
            wait_drained();
            while (items_queued < target)
                add_string();
            if (phase == 1 || phase == 4)
                hold_requests++;
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && draw_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
